@@ rtl/sba_pkg.sv @@
// Shared types and constants for the sector bitmap allocator.
// No dependencies; compile first.
package sba_pkg;

    localparam int MAX_TRACKS_DEF = 35;
    localparam int SECTORS        = 16;
    localparam logic [7:0] TRACKS_RESET = 8'd35;

    typedef enum logic [2:0] {
        CMD_ALLOC = 3'd0,
        CMD_FREE  = 3'd1,
        CMD_MARK  = 3'd2,
        CMD_LOAD  = 3'd3,
        CMD_READ  = 3'd4,
        CMD_QUERY = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        BOP_TEST,
        BOP_SET,
        BOP_CLR,
        BOP_FIND
    } t_bop;

    typedef struct packed {
        logic [SECTORS-1:0] new_word;
        logic               bit_val;
        logic               found;
        logic [3:0]         sec;
    } t_bop_res;

endpackage

@@ rtl/sba_in_if.sv @@
// Command channel: valid/ready plus one command beat.
// No dependencies.
interface sba_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [5:0]  track_in;
    logic [3:0]  sector_in;
    logic [15:0] mask_in;

    modport source (output valid, cmd, track_in, sector_in, mask_in, input ready);
    modport sink   (input valid, cmd, track_in, sector_in, mask_in, output ready);
endinterface

@@ rtl/sba_out_if.sv @@
// Result channel: valid/ready plus one result beat.
// No dependencies.
interface sba_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  track_out;
    logic [3:0]  sector_out;
    logic [15:0] mask_out;
    logic        is_free;
    logic [5:0]  last_track;

    modport source (output valid, status, track_out, sector_out, mask_out, is_free,
                    last_track, input ready);
    modport sink   (input valid, status, track_out, sector_out, mask_out, is_free,
                    last_track, output ready);
endinterface

@@ rtl/sba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 35
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

@@ rtl/sba_bitop.sv @@
// Shared track-word unit: set, clear, test or find-highest-free on one word.
// Depends on sba_pkg.
module sba_bitop (
    input  logic [sba_pkg::SECTORS-1:0] i_word,
    input  logic [3:0]                  i_sec,
    input  sba_pkg::t_bop               i_op,
    output sba_pkg::t_bop_res           o_res
);
    import sba_pkg::*;

    logic             found;
    logic [3:0]       hi_sec;
    logic [SECTORS-1:0] sel_bit;
    logic [SECTORS-1:0] find_bit;

    // highest set bit wins, so sector 15 is tried first
    always_comb begin
        found  = 1'b0;
        hi_sec = 4'd0;
        for (int i = 0; i < SECTORS; i++) begin
            if (i_word[i]) begin
                found  = 1'b1;
                hi_sec = 4'(i);
            end
        end
    end

    assign sel_bit  = SECTORS'(1) << i_sec;
    assign find_bit = found ? (SECTORS'(1) << hi_sec) : '0;

    always_comb begin
        o_res.bit_val = i_word[i_sec];
        o_res.found   = found;
        o_res.sec     = hi_sec;
        unique case (i_op)
            BOP_SET:  o_res.new_word = i_word | sel_bit;
            BOP_CLR:  o_res.new_word = i_word & ~sel_bit;
            BOP_FIND: o_res.new_word = i_word & ~find_bit;
            default:  o_res.new_word = i_word;
        endcase
    end
endmodule

@@ rtl/sector_bitmap_allocator.sv @@
// Sector bitmap allocator: one 16-bit free mask per track in a RAM, one command per beat.
// Free/mark/load/read/query pass through an exec state; range errors, unused codes
// and allocate on a one-track disk go straight to done; allocate sweeps from track 1
// upward to a free sector, up to count-1 tracks (34 at defaults), one track word per cycle.
// Throughput: one command at a time; a new beat is taken once the result is queued.
// Reset (sync, active low): per-track valid flags cleared so every sector reads used.
module sector_bitmap_allocator #(
    parameter int MAX_TRACKS = sba_pkg::MAX_TRACKS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sba_in_if.sink       s_in,
    sba_out_if.source    m_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import sba_pkg::*;

    localparam int AW = $clog2(MAX_TRACKS);
    localparam logic [7:0]  MaxT8  = 8'(MAX_TRACKS);
    localparam logic [6:0]  TrkLim = 7'(MAX_TRACKS);

    // control state
    t_state              r_state, n_state;
    logic [7:0]          r_tracks;
    logic [MAX_TRACKS-1:0] r_valid;
    logic [5:0]          r_last, n_last;
    logic                r_out_valid;

    // command and working registers
    logic [2:0]          r_cmd;
    logic [5:0]          r_trk;
    logic [3:0]          r_sec;
    logic [15:0]         r_mask;
    logic [AW-1:0]       r_chk, n_chk;

    // pending result
    logic [1:0]          r_status, n_status;
    logic [5:0]          r_track, n_track;
    logic [3:0]          r_sector, n_sector;
    logic [15:0]         r_mres, n_mres;
    logic                r_free, n_free;

    // output beat
    logic [1:0]          r_o_status;
    logic [5:0]          r_o_track;
    logic [3:0]          r_o_sector;
    logic [15:0]         r_o_mask;
    logic                r_o_free;
    logic [5:0]          r_o_last;

    logic                in_fire, in_range, out_load, cfg_wr;
    logic [7:0]          n_eff;
    logic                last_chk;
    logic                rd_en, we;
    logic [AW-1:0]       rd_addr, wr_addr, idx;
    logic [15:0]         rd_data, wr_data, cur_word;
    t_bop                bop;
    t_bop_res            bres;

    // ---- configuration port ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {24'd0, r_tracks} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracks <= TRACKS_RESET;
        end else if (cfg_wr) begin
            r_tracks <= pwdata[7:0];
        end
    end

    // effective track count bounds the sweep
    assign n_eff    = (r_tracks == 8'd0 || r_tracks > MaxT8) ? MaxT8 : r_tracks;
    assign last_chk = (8'(r_chk) == n_eff - 8'd1);

    assign in_fire  = s_in.valid && s_in.ready;
    assign in_range = {1'b0, s_in.track_in} < TrkLim;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || m_out.ready);

    // ---- bitmap store ----
    sba_ram #(
        .WIDTH (SECTORS),
        .DEPTH (MAX_TRACKS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // a track never written since reset reads as all used
    assign idx      = (r_state == S_SCAN) ? r_chk : r_trk[AW-1:0];
    assign cur_word = r_valid[idx] ? rd_data : 16'd0;

    sba_bitop u_bitop (
        .i_word (cur_word),
        .i_sec  (r_sec),
        .i_op   (bop),
        .o_res  (bres)
    );

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (s_in.cmd == CMD_ALLOC) begin
                        n_state = (n_eff <= 8'd1) ? S_DONE : S_SCAN;
                    end else if (s_in.cmd <= CMD_QUERY && in_range) begin
                        n_state = S_EXEC;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_EXEC: n_state = S_DONE;
            S_SCAN: begin
                if (bres.found || last_chk) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---- sequencer outputs ----
    always_comb begin
        s_in.ready = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        we         = 1'b0;
        wr_addr    = r_trk[AW-1:0];
        wr_data    = bres.new_word;
        bop        = BOP_TEST;
        unique case (r_state)
            S_IDLE: begin
                // ready is high here, so valid alone marks the accepted beat
                s_in.ready = 1'b1;
                if (s_in.cmd == CMD_ALLOC) begin
                    rd_addr = AW'(1);
                    rd_en   = s_in.valid;
                end else begin
                    rd_addr = s_in.track_in[AW-1:0];
                    rd_en   = s_in.valid && in_range;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_FREE: begin
                        bop = BOP_SET;
                        we  = 1'b1;
                    end
                    CMD_MARK: begin
                        bop = BOP_CLR;
                        we  = 1'b1;
                    end
                    CMD_LOAD: begin
                        we      = 1'b1;
                        wr_data = r_mask;
                    end
                    default: bop = BOP_TEST;
                endcase
            end
            S_SCAN: begin
                // fetch the next track while this one is inspected
                bop     = BOP_FIND;
                rd_addr = r_chk + AW'(1);
                rd_en   = ({1'b0, r_chk} + (AW+1)'(1)) < (AW+1)'(MAX_TRACKS);
                we      = bres.found;
                wr_addr = r_chk;
            end
            S_DONE: s_in.ready = 1'b0;
            default: s_in.ready = 1'b0;
        endcase
    end

    // ---- result datapath ----
    always_comb begin
        n_status = r_status;
        n_track  = r_track;
        n_sector = r_sector;
        n_mres   = r_mres;
        n_free   = r_free;
        n_chk    = r_chk;
        n_last   = r_last;
        if (r_state == S_IDLE && in_fire) begin
            n_status = ST_OK;
            n_track  = 6'd0;
            n_sector = 4'd0;
            n_mres   = 16'd0;
            n_free   = 1'b0;
            n_chk    = AW'(1);
            if (s_in.cmd == CMD_ALLOC) begin
                if (n_eff <= 8'd1) begin
                    n_status = ST_FULL;
                end
            end else if (s_in.cmd <= CMD_QUERY && !in_range) begin
                n_status = ST_RANGE;
            end
        end else if (r_state == S_EXEC) begin
            if (r_cmd == CMD_READ) begin
                n_mres = cur_word;
            end else if (r_cmd == CMD_QUERY) begin
                n_free = bres.bit_val;
            end
        end else if (r_state == S_SCAN) begin
            if (bres.found) begin
                n_track  = 6'(r_chk);
                n_sector = bres.sec;
                n_last   = 6'(r_chk);
            end else if (last_chk) begin
                n_status = ST_FULL;
            end else begin
                n_chk = r_chk + AW'(1);
            end
        end
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_last      <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            if (we) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd  <= s_in.cmd;
            r_trk  <= s_in.track_in;
            r_sec  <= s_in.sector_in;
            r_mask <= s_in.mask_in;
        end
        r_chk    <= n_chk;
        r_status <= n_status;
        r_track  <= n_track;
        r_sector <= n_sector;
        r_mres   <= n_mres;
        r_free   <= n_free;
        if (out_load) begin
            r_o_status <= r_status;
            r_o_track  <= r_track;
            r_o_sector <= r_sector;
            r_o_mask   <= r_mres;
            r_o_free   <= r_free;
            r_o_last   <= r_last;
        end
    end

    assign m_out.valid      = r_out_valid;
    assign m_out.status     = r_o_status;
    assign m_out.track_out  = r_o_track;
    assign m_out.sector_out = r_o_sector;
    assign m_out.mask_out   = r_o_mask;
    assign m_out.is_free    = r_o_free;
    assign m_out.last_track = r_o_last;

    // ---- checks ----
    // track 0 is never inspected by the sweep
    a_no_track0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_chk != '0))
        else $error("allocate sweep reached track 0");

    // a beat queued from the done state shows on the port next cycle
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> m_out.valid)
        else $error("result lost between done state and output");

    // a successful allocate reports the track it also records as last
    a_alloc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && m_out.status == ST_OK && m_out.track_out != 6'd0)
        |-> (m_out.track_out == m_out.last_track))
        else $error("allocated track differs from last track");

    // failed commands carry no mask or free flag
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && m_out.status != ST_OK)
        |-> (m_out.mask_out == 16'd0 && !m_out.is_free))
        else $error("error beat carries data");
endmodule

@@ test/sector_bitmap_allocator_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for sector_bitmap_allocator: directed and random commands,
// an in-bench sector-map scoreboard, and random stalls on both channels.
// Depends on rtl/sba_pkg.sv, rtl/sba_in_if.sv, rtl/sba_out_if.sv and the block itself.
module sector_bitmap_allocator_test;
    import sba_pkg::*;

    localparam int TRACKS = MAX_TRACKS_DEF;
    // Codes 6 and 7 have no command behind them; the block must answer with zeros, last_track apart.
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam logic [2:0] REG_TRACKS_ADDR = 3'd0;
    localparam int WATCHDOG_LIMIT = 3000;  // well above the longest hold and the worst allocate
    localparam int LONG_HOLD = 250;
    localparam int DRAIN_CYCLES = 40;       // covers the slowest allocate sweep
    localparam int NUM_SETTINGS = 8;
    localparam int BEATS_PER_SETTING = 235;

    // One result beat as the block should present it.
    typedef struct packed {
        t_status     status;
        logic [5:0]  trk;
        logic [3:0]  sec;
        logic [15:0] mask;
        logic        is_free;
        logic [5:0]  last;
    } t_outcome;

    // Mirror of the free-sector map plus the queue of results still owed.
    class sector_map_scoreboard;
        logic [15:0] free_words [TRACKS];
        logic [5:0]  last_alloc;
        logic [7:0]  track_count;
        t_outcome    pending_outcomes [$];
        int errors;
        int beats_seen;
        int allocs_ok;
        int disk_fulls;
        int range_errs;

        function new();
            foreach (free_words[t]) free_words[t] = '0;
            last_alloc  = '0;
            track_count = TRACKS_RESET;
            errors = 0;
            beats_seen = 0;
            allocs_ok = 0;
            disk_fulls = 0;
            range_errs = 0;
        endfunction

        function void set_track_count(logic [7:0] value);
            track_count = value;
        endfunction

        function int pending_count();
            return pending_outcomes.size();
        endfunction

        task report(string what, logic [15:0] want, logic [15:0] got);
            errors++;
            if (errors <= 50)
                $display("[%0t] MISMATCH %s: expected %0h, got %0h", $realtime, what, want, got);
        endtask

        // Works out the result of one accepted command and updates the map.
        function void note_command(logic [2:0] op, logic [5:0] trk, logic [3:0] sec,
                                   logic [15:0] mask);
            t_outcome o;
            int span;
            int t;
            int s;
            bit hit;
            o = '0;
            o.status = ST_OK;
            hit = 1'b0;
            if (op == CMD_ALLOC) begin
                span = (track_count == 0 || track_count > TRACKS) ? TRACKS : track_count;
                // tracks rising from 1, sectors falling from 15
                for (t = 1; t < span && !hit; t++) begin
                    for (s = 15; s >= 0 && !hit; s--) begin
                        if (free_words[t][s]) begin
                            free_words[t][s] = 1'b0;
                            last_alloc = 6'(t);
                            o.trk = 6'(t);
                            o.sec = 4'(s);
                            hit = 1'b1;
                        end
                    end
                end
                if (hit) allocs_ok++;
                else begin
                    o.status = ST_FULL;
                    disk_fulls++;
                end
            end else if (op <= CMD_QUERY) begin
                if (trk >= TRACKS) begin
                    o.status = ST_RANGE;
                    range_errs++;
                end else begin
                    case (op)
                        CMD_FREE:  free_words[trk][sec] = 1'b1;
                        CMD_MARK:  free_words[trk][sec] = 1'b0;
                        CMD_LOAD:  free_words[trk] = mask;
                        CMD_READ:  o.mask = free_words[trk];
                        default:   o.is_free = free_words[trk][sec];
                    endcase
                end
            end
            o.last = last_alloc;
            pending_outcomes.insert(pending_outcomes.size(), o);
        endfunction

        task check_result(t_outcome got);
            t_outcome want;
            beats_seen++;
            if (pending_outcomes.size() == 0) begin
                report("unexpected result beat", '0, 16'(got.status));
                return;
            end
            want = pending_outcomes.pop_front();
            if (got.status !== want.status)   report("status", want.status, got.status);
            if (got.trk !== want.trk)         report("track_out", want.trk, got.trk);
            if (got.sec !== want.sec)         report("sector_out", want.sec, got.sec);
            if (got.mask !== want.mask)       report("mask_out", want.mask, got.mask);
            if (got.is_free !== want.is_free) report("is_free", want.is_free, got.is_free);
            if (got.last !== want.last)       report("last_track", want.last, got.last);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sba_in_if  in_bus ();
    sba_out_if out_bus ();

    sector_map_scoreboard sb;
    int  results_seen;
    bit  tx_steady;
    bit  rx_steady;

    sector_bitmap_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_bus),
        .m_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mostly short gaps, the odd long one.
    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    // Presents one command beat from a falling edge and holds it until taken.
    // Returns at the falling edge after the accepting rising edge, valid still high.
    task automatic offer_command(input logic [2:0] op, input logic [5:0] trk,
                                 input logic [3:0] sec, input logic [15:0] mask);
        in_bus.valid     <= 1'b1;
        in_bus.cmd       <= op;
        in_bus.track_in  <= trk;
        in_bus.sector_in <= sec;
        in_bus.mask_in   <= mask;
        do @(posedge i_clk); while (!in_bus.ready);
        sb.note_command(op, trk, sec, mask);
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every owed result has come back, then a short pause.
    task automatic drain_results();
        in_bus.valid <= 1'b0;
        while (sb.pending_count() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // APB write of tracks_in_use then a read-back; the block must be idle.
    task automatic write_track_count(input logic [7:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TRACKS_ADDR;
        pwdata  <= {24'b0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_track_count(value);
        if (readback[7:0] !== value) sb.report("tracks_in_use read-back", value, readback[7:0]);
    endtask

    // Random command, biased so that loads and frees keep allocation interesting.
    task automatic offer_random_command();
        int unsigned pick;
        logic [2:0]  op;
        logic [5:0]  trk;
        logic [3:0]  sec;
        logic [15:0] mask;
        pick = $urandom_range(0, 99);
        // low tracks most of the time so small track counts still see hits
        trk = ($urandom_range(0, 4) < 3) ? 6'($urandom_range(0, 7))
                                         : 6'($urandom_range(0, TRACKS - 1));
        sec = 4'($urandom);
        case ($urandom_range(0, 5))
            0, 1:    mask = 16'($urandom);
            2:       mask = 16'h0001 << $urandom_range(0, 15);
            3:       mask = 16'h0000;
            4:       mask = 16'hFFFF;
            default: mask = 16'($urandom) & 16'($urandom);
        endcase
        if (pick < 30)      op = CMD_ALLOC;
        else if (pick < 45) op = CMD_FREE;
        else if (pick < 55) op = CMD_MARK;
        else if (pick < 65) op = CMD_LOAD;
        else if (pick < 75) op = CMD_READ;
        else if (pick < 87) op = CMD_QUERY;
        else if (pick < 94) begin
            // track past the end of the map
            op  = 3'($urandom_range(CMD_FREE, CMD_QUERY));
            trk = 6'($urandom_range(TRACKS, 63));
        end else begin
            op = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
        end
        offer_command(op, trk, sec, mask);
    endtask

    // Directed opening at the reset track count of 35.
    task automatic run_directed();
        offer_command(CMD_ALLOC, 6'd0,  4'd0,  16'h0000);  // empty map: disk full
        offer_command(CMD_READ,  6'd0,  4'd0,  16'h0000);
        offer_command(CMD_QUERY, 6'd0,  4'd0,  16'hFFFF);
        offer_command(CMD_LOAD,  6'd1,  4'd0,  16'hFFFF);
        offer_command(CMD_ALLOC, 6'd63, 4'd15, 16'hFFFF);  // takes track 1 sector 15
        offer_command(CMD_READ,  6'd1,  4'd15, 16'h0000);
        offer_command(CMD_MARK,  6'd1,  4'd14, 16'h0000);
        offer_command(CMD_QUERY, 6'd1,  4'd14, 16'h0000);
        offer_command(CMD_FREE,  6'd1,  4'd15, 16'h0000);
        offer_command(CMD_QUERY, 6'd1,  4'd15, 16'h0000);
        offer_command(CMD_LOAD,  6'd1,  4'd0,  16'h0000);
        offer_command(CMD_LOAD,  6'd34, 4'd0,  16'h0001);
        offer_command(CMD_ALLOC, 6'd0,  4'd0,  16'h0000);  // last track, sector 0
        offer_command(CMD_ALLOC, 6'd0,  4'd0,  16'h0000);  // full again
        offer_command(CMD_LOAD,  6'd0,  4'd7,  16'hFFFF);  // track 0 is never handed out
        offer_command(CMD_ALLOC, 6'd0,  4'd0,  16'h0000);
        offer_command(CMD_READ,  6'd0,  4'd0,  16'h0000);
        offer_command(CMD_FREE,  6'd63, 4'd15, 16'hFFFF);  // out-of-range track
        offer_command(CMD_MARK,  6'd35, 4'd0,  16'h0000);
        offer_command(CMD_LOAD,  6'd63, 4'd0,  16'hAAAA);
        offer_command(CMD_READ,  6'd35, 4'd0,  16'h5555);
        offer_command(CMD_QUERY, 6'd40, 4'd9,  16'h0000);
        offer_command(CMD_SPARE_6, 6'd5, 4'd3, 16'h5555);  // spare codes
        offer_command(CMD_SPARE_7, 6'd63, 4'd15, 16'hFFFF);
    endtask

    // Result side: accepted beats go straight to the scoreboard.
    always @(posedge i_clk) begin
        t_outcome got;
        if (out_bus.valid && out_bus.ready) begin
            got.status  = t_status'(out_bus.status);
            got.trk     = out_bus.track_out;
            got.sec     = out_bus.sector_out;
            got.mask    = out_bus.mask_out;
            got.is_free = out_bus.is_free;
            got.last    = out_bus.last_track;
            sb.check_result(got);
            results_seen++;
        end
    end

    // Receiver: random stalls, steady stretches, and two long hold-offs so the
    // block backs up and stalls the command channel.
    initial begin : result_sink
        int holds_done;
        out_bus.ready = 1'b0;
        holds_done = 0;
        rx_steady = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done < 2 && results_seen >= (holds_done == 0 ? 400 : 1300)) begin
                out_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                holds_done++;
            end
            if ($urandom_range(0, 99) == 0) rx_steady = !rx_steady;
            if (!rx_steady && $urandom_range(0, 3) == 0) begin
                out_bus.ready <= 1'b0;
                repeat (pick_gap()) @(negedge i_clk);
            end
            out_bus.ready <= 1'b1;
        end
    end

    // Watchdog: too long without a beat on either channel ends the run.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet = 0;
            else quiet++;
        end
        $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] settings [NUM_SETTINGS];
        int ph;
        int k;
        // extremes first: 0 and 255 both fall back to the full map
        settings[0] = 8'd0;
        settings[1] = 8'd1;
        settings[2] = 8'd2;
        settings[3] = 8'd255;
        settings[4] = 8'd36;
        settings[5] = 8'd35;
        settings[6] = 8'd34;
        settings[7] = 8'($urandom_range(3, 33));

        i_rst_n          = 1'b0;
        in_bus.valid     = 1'b0;
        in_bus.cmd       = CMD_ALLOC;
        in_bus.track_in  = '0;
        in_bus.sector_in = '0;
        in_bus.mask_in   = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = REG_TRACKS_ADDR;
        pwdata  = '0;
        results_seen = 0;
        tx_steady = 1'b0;
        sb = new();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();

        for (ph = 0; ph < NUM_SETTINGS; ph++) begin
            drain_results();
            write_track_count(settings[ph]);
            for (k = 0; k < BEATS_PER_SETTING; k++) begin
                // sender pauses until everything owed is back
                if (k == 100 && (ph == 2 || ph == 5)) drain_results();
                if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
                if (!tx_steady && $urandom_range(0, 2) == 0) begin
                    in_bus.valid <= 1'b0;
                    repeat (pick_gap()) @(negedge i_clk);
                end
                offer_random_command();
            end
        end

        in_bus.valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending_count() != 0) sb.report("results never returned", '0, 16'(sb.pending_count()));

        $display("Covered %0d result beats over %0d track-count settings (0, 1, 2, 255 among them)",
                 sb.beats_seen, NUM_SETTINGS);
        $display("  %0d sectors allocated, %0d disk-full and %0d out-of-range answers, %0d errors",
                 sb.allocs_ok, sb.disk_fulls, sb.range_errs, sb.errors);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
